FILE: rtl/core/clr_pkg.sv
// Shared types, codes and default sizes for the clipped line rasterizer.
package clr_pkg;

	localparam int DEF_LOGICAL_WIDTH  = 128;
	localparam int DEF_LOGICAL_HEIGHT = 128;
	localparam int DEF_PIXEL_SCALE    = 2;

	// physical coordinates: 16-bit logical times a scale of at most 4, plus room for differences
	localparam int CW          = 20;
	localparam int PROD_W      = 2 * CW;
	localparam int CLIP_ROUNDS = 16;
	localparam int CMDQ_DEPTH  = 2;

	localparam logic [1:0] FUNC_DRAW  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [3:0]         color;
	} req_t;

	typedef struct packed {
		logic [3:0] read_color;
		logic       visible;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		coord_t     ax;
		coord_t     ay;
		coord_t     bx;
		coord_t     by;
		logic [3:0] color;
	} cmd_t;

endpackage

FILE: rtl/core/clr_front.sv
// Command front end: classify the command and map logical points to pixel centers.
module clr_front #(
	parameter int LOGICAL_WIDTH  = clr_pkg::DEF_LOGICAL_WIDTH,
	parameter int LOGICAL_HEIGHT = clr_pkg::DEF_LOGICAL_HEIGHT,
	parameter int PIXEL_SCALE    = clr_pkg::DEF_PIXEL_SCALE
) (
	input  clr_pkg::req_t req,
	output clr_pkg::cmd_t cmd
);
	import clr_pkg::*;

	localparam coord_t Scale = coord_t'(PIXEL_SCALE);
	localparam coord_t Half  = coord_t'(PIXEL_SCALE / 2);
	localparam logic signed [15:0] LwLim = 16'(LOGICAL_WIDTH);
	localparam logic signed [15:0] LhLim = 16'(LOGICAL_HEIGHT);

	function automatic coord_t to_phys(logic signed [15:0] v);
		coord_t w;
		w = coord_t'(v);
		return w * Scale + Half;
	endfunction

	logic read_ok;

	assign read_ok = (req.start_x >= 16'sd0) && (req.start_x < LwLim) &&
	                 (req.start_y >= 16'sd0) && (req.start_y < LhLim);

	always_comb begin
		cmd.ax    = to_phys(req.start_x);
		cmd.ay    = to_phys(req.start_y);
		cmd.bx    = to_phys(req.end_x);
		cmd.by    = to_phys(req.end_y);
		cmd.color = req.color;
		case (req.func)
			FUNC_DRAW:  cmd.op = OP_DRAW;
			FUNC_READ:  cmd.op = read_ok ? OP_READ : OP_NONE;
			FUNC_CLEAR: cmd.op = OP_CLEAR;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: rtl/core/clr_cmd_fifo.sv
// Short command queue between the front end and the drawing engine.
module clr_cmd_fifo #(
	parameter int DEPTH = clr_pkg::CMDQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  clr_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output clr_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import clr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full   = (cnt_q == NW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/clr_div.sv
// Radix-2 restoring divider for the clip intersections, one quotient bit per cycle.
module clr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [clr_pkg::PROD_W-1:0] dividend,
	input  logic [clr_pkg::CW-1:0]     divisor,
	output logic                       busy,
	output logic                       done,
	output logic [clr_pkg::PROD_W-1:0] quotient
);
	import clr_pkg::*;

	localparam int KW = $clog2(PROD_W + 1);

	logic [CW:0]       rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [CW-1:0]     dvs_q;
	logic [KW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [CW:0]       trial;
	logic              fits;

	assign trial    = {rem_q[CW-1:0], quo_q[PROD_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == KW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) busy_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/clr_back.sv
// Drawing engine: clip, Bresenham walk, pixel read, screen fill and the frame store.
module clr_back #(
	parameter int LOGICAL_WIDTH  = clr_pkg::DEF_LOGICAL_WIDTH,
	parameter int LOGICAL_HEIGHT = clr_pkg::DEF_LOGICAL_HEIGHT,
	parameter int PIXEL_SCALE    = clr_pkg::DEF_PIXEL_SCALE
) (
	input  logic          clk,
	input  logic          arst_n,
	input  clr_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output clr_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_pop,
	output logic          init_busy
);
	import clr_pkg::*;

	localparam int PHYS_W      = LOGICAL_WIDTH * PIXEL_SCALE;
	localparam int PHYS_H      = LOGICAL_HEIGHT * PIXEL_SCALE;
	localparam int ROW_BYTES   = PHYS_W / 2;
	localparam int STORE_BYTES = PHYS_W * PHYS_H / 2;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int IXW         = $clog2(STORE_BYTES + 1);
	localparam int XW          = $clog2(PHYS_W);
	localparam int YW          = $clog2(PHYS_H);
	localparam int RW          = $clog2(CLIP_ROUNDS + 1);
	localparam coord_t PwC     = coord_t'(PHYS_W);
	localparam coord_t PhC     = coord_t'(PHYS_H);

	localparam logic [3:0] ST_INIT      = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_CLEAR     = 4'd2;
	localparam logic [3:0] ST_READ_RD   = 4'd3;
	localparam logic [3:0] ST_READ_DONE = 4'd4;
	localparam logic [3:0] ST_CLIP_TEST = 4'd5;
	localparam logic [3:0] ST_CLIP_MUL  = 4'd6;
	localparam logic [3:0] ST_DIV_GO    = 4'd7;
	localparam logic [3:0] ST_CLIP_DIV  = 4'd8;
	localparam logic [3:0] ST_CLIP_UPD  = 4'd9;
	localparam logic [3:0] ST_BRES_INIT = 4'd10;
	localparam logic [3:0] ST_PLOT_RD   = 4'd11;
	localparam logic [3:0] ST_PLOT_WR   = 4'd12;
	localparam logic [3:0] ST_RESP      = 4'd13;

	function automatic logic [3:0] region(coord_t x, coord_t y);
		logic [3:0] r;
		r = '0;
		if (x < 0) r[0] = 1'b1;
		else if (x >= PwC) r[1] = 1'b1;
		if (y < 0) r[2] = 1'b1;
		else if (y >= PhC) r[3] = 1'b1;
		return r;
	endfunction

	function automatic logic on_screen(coord_t x, coord_t y);
		return (x >= 0) && (y >= 0) && (x < PwC) && (y < PhC);
	endfunction

	logic [3:0] state_q;

	coord_t     ax_q, ay_q, bx_q, by_q;
	logic [3:0] color_q;
	logic [RW-1:0] round_q;

	coord_t mul_a_q, mul_b_q, den_q, base_q, bnd_q;
	logic   edge_y_q, use_a_q, neg_q;
	logic signed [PROD_W-1:0] prod_q;

	coord_t dx_q, dy_q, err_q;
	logic   sx_neg_q, sy_neg_q;

	logic [AW-1:0] cnt_q, addr_q;
	logic          wr_ok_q, odd_q;
	logic [3:0]    rc_q;
	logic          vis_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;

	logic [3:0] ra, rb, rsel;
	coord_t     bnd, den;
	logic       div_start, div_busy, div_done;
	logic [PROD_W-1:0] div_num, div_quo;
	logic [CW-1:0]     div_den;
	coord_t     qv, newc;
	coord_t     e2;
	logic       step_x, step_y;
	logic [IXW-1:0] lin;
	logic [AW-1:0]  raddr;
	logic           mem_we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic           slot_free;

	assign ra   = region(ax_q, ay_q);
	assign rb   = region(bx_q, by_q);
	assign rsel = (ra != '0) ? ra : rb;

	always_comb begin
		if (rsel[3] || rsel[2]) begin
			bnd = rsel[3] ? PhC - coord_t'(1) : '0;
			den = by_q - ay_q;
		end else begin
			bnd = rsel[1] ? PwC - coord_t'(1) : '0;
			den = bx_q - ax_q;
		end
	end

	// magnitudes into the divider, sign restored afterwards (truncation toward zero)
	assign div_start = (state_q == ST_DIV_GO);
	assign div_num   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign div_den   = den_q[CW-1] ? CW'(-den_q) : CW'(den_q);
	assign qv        = neg_q ? -coord_t'(div_quo[CW-1:0]) : coord_t'(div_quo[CW-1:0]);
	assign newc      = base_q + qv;

	clr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign e2     = err_q <<< 1;
	assign step_x = e2 > -dy_q;
	assign step_y = e2 < dx_q;

	// byte address of the current point from its low coordinate bits; an address past the store folds to byte 0
	assign lin   = IXW'(ay_q[YW-1:0]) * IXW'(ROW_BYTES) + IXW'(ax_q[XW-1:1]);
	assign raddr = (lin < IXW'(STORE_BYTES)) ? lin[AW-1:0] : '0;

	always_comb begin
		mem_we = 1'b0;
		waddr  = cnt_q;
		wdata  = '0;
		case (state_q)
			ST_INIT: mem_we = 1'b1;
			ST_CLEAR: begin
				mem_we = 1'b1;
				wdata  = {color_q, color_q};
			end
			ST_PLOT_WR: begin
				mem_we = wr_ok_q;
				waddr  = addr_q;
				wdata  = odd_q ? {color_q, rdata_q[3:0]} : {rdata_q[7:4], color_q};
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (state_q == ST_PLOT_RD || state_q == ST_READ_RD) rdata_q <= mem[raddr];
	end

	assign slot_free = !rsp_valid_q || rsp_pop;
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign init_busy = (state_q == ST_INIT);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q    <= cmd.ax;
				ay_q    <= cmd.ay;
				bx_q    <= cmd.bx;
				by_q    <= cmd.by;
				color_q <= cmd.color;
				rc_q    <= '0;
				vis_q   <= 1'b0;
			end
			ST_CLIP_TEST: begin
				use_a_q  <= (ra != '0);
				edge_y_q <= rsel[3] || rsel[2];
				bnd_q    <= bnd;
				den_q    <= den;
				if (rsel[3] || rsel[2]) begin
					mul_a_q <= bx_q - ax_q;
					mul_b_q <= bnd - ay_q;
					base_q  <= ax_q;
				end else begin
					mul_a_q <= by_q - ay_q;
					mul_b_q <= bnd - ax_q;
					base_q  <= ay_q;
				end
			end
			ST_CLIP_MUL: prod_q <= mul_a_q * mul_b_q;
			ST_DIV_GO:   neg_q  <= prod_q[PROD_W-1] ^ den_q[CW-1];
			ST_CLIP_UPD: begin
				if (use_a_q) begin
					ax_q <= edge_y_q ? newc : bnd_q;
					ay_q <= edge_y_q ? bnd_q : newc;
				end else begin
					bx_q <= edge_y_q ? newc : bnd_q;
					by_q <= edge_y_q ? bnd_q : newc;
				end
			end
			ST_BRES_INIT: begin
				sx_neg_q <= !(bx_q > ax_q);
				sy_neg_q <= !(by_q > ay_q);
				dx_q     <= (bx_q > ax_q) ? bx_q - ax_q : ax_q - bx_q;
				dy_q     <= (by_q > ay_q) ? by_q - ay_q : ay_q - by_q;
				err_q    <= ((bx_q > ax_q) ? bx_q - ax_q : ax_q - bx_q) -
				            ((by_q > ay_q) ? by_q - ay_q : ay_q - by_q);
			end
			ST_PLOT_RD, ST_READ_RD: begin
				addr_q  <= raddr;
				odd_q   <= ax_q[0];
				wr_ok_q <= on_screen(ax_q, ay_q);
			end
			ST_READ_DONE: begin
				rc_q  <= odd_q ? rdata_q[7:4] : rdata_q[3:0];
				vis_q <= 1'b1;
			end
			ST_PLOT_WR: begin
				if (!(ax_q == bx_q && ay_q == by_q)) begin
					err_q <= err_q - (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
					if (step_x) ax_q <= sx_neg_q ? ax_q - coord_t'(1) : ax_q + coord_t'(1);
					if (step_y) ay_q <= sy_neg_q ? ay_q - coord_t'(1) : ay_q + coord_t'(1);
				end else begin
					vis_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (state_q == ST_RESP && slot_free) begin
			rsp_q.read_color <= rc_q;
			rsp_q.visible    <= vis_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			round_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && slot_free) rsp_valid_q <= 1'b1;
			else if (rsp_pop)                    rsp_valid_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (cnt_q == AW'(STORE_BYTES - 1)) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						round_q <= '0;
						cnt_q   <= '0;
						case (cmd.op)
							OP_DRAW:  state_q <= ST_CLIP_TEST;
							OP_READ:  state_q <= ST_READ_RD;
							OP_CLEAR: state_q <= ST_CLEAR;
							default:  state_q <= ST_RESP;
						endcase
					end
				end
				ST_READ_RD:   state_q <= ST_READ_DONE;
				ST_READ_DONE: state_q <= ST_RESP;
				ST_CLIP_TEST: begin
					// round limit first: a segment accepted only after the last round is dropped
					if (round_q == RW'(CLIP_ROUNDS))  state_q <= ST_RESP;
					else if ((ra | rb) == '0)         state_q <= ST_BRES_INIT;
					else if ((ra & rb) != '0)         state_q <= ST_RESP;
					else if (den == '0)               state_q <= ST_RESP;
					else begin
						round_q <= round_q + 1'b1;
						state_q <= ST_CLIP_MUL;
					end
				end
				ST_CLIP_MUL:  state_q <= ST_DIV_GO;
				ST_DIV_GO:    state_q <= ST_CLIP_DIV;
				ST_CLIP_DIV:  if (div_done) state_q <= ST_CLIP_UPD;
				ST_CLIP_UPD:  state_q <= ST_CLIP_TEST;
				ST_BRES_INIT: state_q <= ST_PLOT_RD;
				ST_PLOT_RD:   state_q <= ST_PLOT_WR;
				ST_PLOT_WR: begin
					if (ax_q == bx_q && ay_q == by_q) state_q <= ST_RESP;
					else                              state_q <= ST_PLOT_RD;
				end
				ST_RESP: if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_plot_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PLOT_RD |-> on_screen(ax_q, ay_q))
		else $error("walk left the screen");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_CLIP_DIV)
		else $error("divider busy outside the divide step");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("result loaded outside the response step");

endmodule

FILE: rtl/core/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer: queue ports, front end, command queue, engine.
// A draw is clipped in rounds that each use the divider, then plotted pixel by pixel with a
// read-modify-write on the frame store's read and write ports; one command is worked
// on at a time, up to CMDQ_DEPTH more wait queued.
// Reset: asynchronous, active low; afterwards the frame store, STORE_BYTES bytes (32768 at
// the defaults), is zeroed one byte per cycle while full stays high.
module clipped_line_rasterizer #(
	parameter int LOGICAL_WIDTH  = clr_pkg::DEF_LOGICAL_WIDTH,
	parameter int LOGICAL_HEIGHT = clr_pkg::DEF_LOGICAL_HEIGHT,
	parameter int PIXEL_SCALE    = clr_pkg::DEF_PIXEL_SCALE
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  clr_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output clr_pkg::rsp_t rsp
);
	import clr_pkg::*;

	cmd_t front_cmd, queued_cmd;
	logic q_full, q_empty, q_pop;
	logic init_busy, rsp_valid;
	logic in_xfer, out_xfer;

	// hold off input transfers while the store is still being zeroed
	assign full     = q_full || init_busy;
	assign in_xfer  = push && !full;
	assign empty    = !rsp_valid;
	assign out_xfer = pop && rsp_valid;

	// classify and map to pixel centers on the way into the queue
	clr_front #(
		.LOGICAL_WIDTH  (LOGICAL_WIDTH),
		.LOGICAL_HEIGHT (LOGICAL_HEIGHT),
		.PIXEL_SCALE    (PIXEL_SCALE)
	) u_front (
		.req (req),
		.cmd (front_cmd)
	);

	// decouple the accepting side from the engine
	clr_cmd_fifo #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_xfer),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (queued_cmd),
		.empty  (q_empty)
	);

	// clip, walk and store; the result register sits inside the engine
	clr_back #(
		.LOGICAL_WIDTH  (LOGICAL_WIDTH),
		.LOGICAL_HEIGHT (LOGICAL_HEIGHT),
		.PIXEL_SCALE    (PIXEL_SCALE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queued_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_pop   (out_xfer),
		.init_busy (init_busy)
	);

endmodule

FILE: dv/tb_clipped_line_rasterizer.sv
// Self-checking testbench for the clipped line rasterizer: directed table, then random commands.
module tb_clipped_line_rasterizer;
	import clr_pkg::*;

	localparam int LW = DEF_LOGICAL_WIDTH;
	localparam int LH = DEF_LOGICAL_HEIGHT;
	localparam int PS = DEF_PIXEL_SCALE;
	localparam int PW = LW * PS;
	localparam int PH = LH * PS;
	localparam int ROWB = PW / 2;
	localparam int NBYTES = PW * PH / 2;
	localparam int N_RANDOM = 1150;
	// a clear and the post-reset zeroing each walk all NBYTES bytes of the store; long random stalls on top
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		req_t req;
		logic chk;      // whether the typed expected value is checked
		rsp_t want;
	} row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  push = 1'b0;
	logic  pop = 1'b0;
	req_t  req = '0;
	logic  full, empty;
	rsp_t  rsp;

	byte unsigned pixel_bytes[NBYTES];
	rsp_t  rsp_expected[$];
	rsp_t  rsp_typed[$];
	bit    typed_valid[$];
	int    n_fail = 0;
	int    idle_cycles = 0;
	bit    stim_done = 0;
	row_t  directed[$];

	clipped_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		n_fail++;
	endtask

	// frame store model helpers
	function automatic void plot(longint x, longint y, logic [3:0] c);
		int idx;
		if (x < 0 || y < 0 || x >= PW || y >= PH) return;
		idx = int'(y * ROWB + (x >>> 1));
		if (x[0]) pixel_bytes[idx] = {c, pixel_bytes[idx][3:0]};
		else pixel_bytes[idx] = {pixel_bytes[idx][7:4], c};
	endfunction

	function automatic logic [3:0] outcode(longint x, longint y);
		logic [3:0] r;
		r = '0;
		if (x < 0) r[0] = 1'b1;
		else if (x >= PW) r[1] = 1'b1;
		if (y < 0) r[2] = 1'b1;
		else if (y >= PH) r[3] = 1'b1;
		return r;
	endfunction

	// Cohen-Sutherland clip, then Bresenham; returns whether anything survived
	function automatic bit rasterize(longint x0, longint y0, longint x1, longint y1,
			logic [3:0] c);
		logic [3:0] ra, rb, r;
		longint nx, ny, den, dx, dy, sx, sy, err, e2;
		bit ok;
		ra = outcode(x0, y0);
		rb = outcode(x1, y1);
		ok = 0;
		for (int k = 0; k < CLIP_ROUNDS; k++) begin
			if ((ra | rb) == 0) begin
				ok = 1;
				break;
			end
			if ((ra & rb) != 0) break;
			r = (ra != 0) ? ra : rb;
			if (r[3] || r[2]) begin
				ny = r[3] ? PH - 1 : 0;
				den = y1 - y0;
				if (den == 0) break;
				nx = x0 + (x1 - x0) * (ny - y0) / den;
			end else begin
				nx = r[1] ? PW - 1 : 0;
				den = x1 - x0;
				if (den == 0) break;
				ny = y0 + (y1 - y0) * (nx - x0) / den;
			end
			if (r == ra) begin
				x0 = nx; y0 = ny; ra = outcode(nx, ny);
			end else begin
				x1 = nx; y1 = ny; rb = outcode(nx, ny);
			end
		end
		if (!ok) return 0;
		dx = x1 - x0;
		dy = y1 - y0;
		sx = dx > 0 ? 1 : -1;
		sy = dy > 0 ? 1 : -1;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		err = dx - dy;
		forever begin
			plot(x0, y0, c);
			if (x0 == x1 && y0 == y1) break;
			e2 = 2 * err;
			if (e2 > -dy) begin
				err -= dy; x0 += sx;
			end
			if (e2 < dx) begin
				err += dx; y0 += sy;
			end
		end
		return 1;
	endfunction

	function automatic longint center(logic signed [15:0] v);
		return longint'(v) * PS + PS / 2;
	endfunction

	function automatic rsp_t predict_command(req_t r);
		rsp_t o;
		longint px, py, idx;
		o = '0;
		case (r.func)
			FUNC_DRAW: begin
				o.visible = rasterize(center(r.start_x), center(r.start_y),
					center(r.end_x), center(r.end_y), r.color);
			end
			FUNC_READ: begin
				if (r.start_x >= 0 && r.start_x < LW && r.start_y >= 0 && r.start_y < LH) begin
					px = center(r.start_x);
					py = center(r.start_y);
					idx = py * ROWB + (px >>> 1);
					o.read_color = px[0] ? pixel_bytes[idx][7:4] : pixel_bytes[idx][3:0];
					o.visible = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				foreach (pixel_bytes[i]) pixel_bytes[i] = {r.color, r.color};
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic row_t mk(logic [1:0] f, int ax, int ay, int bx, int by, int c,
			bit chk = 0, int rc = 0, int vis = 0);
		row_t t;
		t.req.func = f;
		t.req.start_x = 16'(ax);
		t.req.start_y = 16'(ay);
		t.req.end_x = 16'(bx);
		t.req.end_y = 16'(by);
		t.req.color = 4'(c);
		t.chk = chk;
		t.want.read_color = 4'(rc);
		t.want.visible = 1'(vis);
		return t;
	endfunction

	// random gap: mostly none or short, occasionally long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic int rnd_coord();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(0, LW - 1);
		if (p < 90) return $urandom_range(0, LW + 40) - 20;
		return $urandom_range(0, 65535) - 32768;
	endfunction

	function automatic req_t rnd_command();
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		r.func = (p < 55) ? FUNC_DRAW : (p < 93) ? FUNC_READ : (p < 95) ? FUNC_CLEAR : OP_NONE;
		r.start_x = 16'(rnd_coord());
		r.start_y = 16'(rnd_coord());
		r.end_x = 16'(rnd_coord());
		r.end_y = 16'(rnd_coord());
		r.color = 4'($urandom_range(0, 15));
		// keep about half of the draws short so the run stays quick
		if (r.func == FUNC_DRAW && $urandom_range(0, 3) != 0 && p % 3 != 0) begin
			r.end_x = r.start_x + 16'($urandom_range(0, 16) - 8);
			r.end_y = r.start_y + 16'($urandom_range(0, 16) - 8);
		end
		return r;
	endfunction

	// hand one command over, predict it at the transfer; push drops only for a gap
	task automatic send(req_t r, bit chk, rsp_t want);
		rsp_t pred;
		int n;
		n = gap_len();
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		pred = predict_command(r);
		rsp_expected.push_back(pred);
		typed_valid.push_back(chk);
		rsp_typed.push_back(want);
		if (chk && pred != want)
			report_mismatch("typed row vs predictor", pred, want);
	endtask

	initial begin
		foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
		// reads after reset see a zero store; out-of-screen reads return nothing
		directed.push_back(mk(FUNC_READ, 0, 0, 0, 0, 15, 1, 0, 1));
		directed.push_back(mk(FUNC_READ, 127, 127, -32768, 32767, 15, 1, 0, 1));
		directed.push_back(mk(FUNC_READ, -1, 0, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(FUNC_READ, 0, 128, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(FUNC_READ, -32768, 32767, 0, 0, 0, 1, 0, 0));
		directed.push_back(mk(FUNC_READ, 32767, -32768, 0, 0, 0, 1, 0, 0));
		// fully outside lines are rejected
		directed.push_back(mk(FUNC_DRAW, -10, -10, -5, -20, 7, 1, 0, 0));
		directed.push_back(mk(FUNC_DRAW, 200, 5, 300, 9, 7, 1, 0, 0));
		directed.push_back(mk(FUNC_DRAW, -32768, -32768, 32767, -32768, 9, 1, 0, 0));
		// unused selector does nothing
		directed.push_back(mk(OP_NONE, 32767, 32767, 32767, 32767, 15, 1, 0, 0));
		// drawn lines: single point, diagonal, clipped corner to corner, extremes
		directed.push_back(mk(FUNC_DRAW, 5, 5, 5, 5, 10));
		directed.push_back(mk(FUNC_READ, 5, 5, 0, 0, 0, 1, 10, 1));
		directed.push_back(mk(FUNC_DRAW, 0, 0, 127, 127, 3));
		directed.push_back(mk(FUNC_READ, 64, 64, 0, 0, 0));
		directed.push_back(mk(FUNC_DRAW, -32768, 32767, 32767, -32768, 12));
		directed.push_back(mk(FUNC_DRAW, -50, 20, 300, 90, 6));
		directed.push_back(mk(FUNC_DRAW, 64, -100, 64, 500, 5));
		directed.push_back(mk(FUNC_READ, 64, 100, 0, 0, 0));
		directed.push_back(mk(FUNC_READ, 0, 20, 0, 0, 0));
		// clear fills both nibbles
		directed.push_back(mk(FUNC_CLEAR, 1, 2, 3, 4, 9, 1, 0, 0));
		directed.push_back(mk(FUNC_READ, 3, 0, 0, 0, 0, 1, 9, 1));
		directed.push_back(mk(FUNC_DRAW, 127, 0, 0, 127, 0));
		directed.push_back(mk(FUNC_READ, 127, 0, 0, 0, 0, 1, 0, 1));
		directed.push_back(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) send(directed[i].req, directed[i].chk, directed[i].want);
		for (int n = 0; n < N_RANDOM; n++) send(rnd_command(), 0, '0);
		push <= 1'b0;
		stim_done = 1;
	end

	// result side: random pop stalls, compare each transfer with the oldest prediction
	initial begin
		rsp_t want;
		int n;
		@(posedge arst_n);
		forever begin
			n = gap_len();
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (rsp_expected.size() == 0) begin
				report_mismatch("unexpected result", rsp, 0);
			end else begin
				want = rsp_expected.pop_front();
				void'(typed_valid.pop_front());
				void'(rsp_typed.pop_front());
				if (rsp.read_color !== want.read_color)
					report_mismatch("read_color", rsp.read_color, want.read_color);
				if (rsp.visible !== want.visible)
					report_mismatch("visible", rsp.visible, want.visible);
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (rsp_expected.size() != 0) @(posedge clk);
		// let any stray result show up
		repeat (200) @(posedge clk);
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
